FILE: design/fsde_pkg.sv
// fsde_pkg: shared types and constants of the fixed-support digit enumerator.
// Used by fsde_digit_alu, fixed_support_digit_enumerator_core and its testbench; no dependencies.
package fsde_pkg;

  localparam int CFG_W     = 5;   // width of every configuration register
  localparam int CFG_IDX_W = 2;   // configuration register index
  localparam int REQ_W     = 2;   // request code
  localparam int FIELD_W   = 4;   // digit_index, digit_value, nonzero_rank
  localparam int SLOT_BITS = 4;   // bits per position in the packed vector
  localparam int SLOTS     = 16;
  localparam int VEC_W     = SLOT_BITS * SLOTS;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_ADVANCE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_QUERY   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LOAD    = 2'd2;
  localparam logic [REQ_W-1:0] REQ_RESTART = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIX       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET      = 2'd2;

  // Configuration reset values
  localparam logic [CFG_W-1:0] COUNT_RESET  = 5'd16;
  localparam logic [CFG_W-1:0] RADIX_RESET  = 5'd2;
  localparam logic [CFG_W-1:0] TARGET_RESET = 5'd1;

  // Operation applied by the digit unit on each position of a pass
  typedef enum logic [2:0] {
    OP_SCAN,
    OP_KEEP,
    OP_ADVANCE,
    OP_QUERY,
    OP_LOAD,
    OP_FIRST
  } op_t;

  // Running flags carried from one position to the next
  typedef struct packed {
    logic seen;     // a nonzero digit seen at or below this position
    logic inc;      // an increasable position seen
    logic zab;      // a zero right above a nonzero digit seen
    logic prev_nz;  // previous position nonzero
    logic hit;      // neighbor query found its digit
  } track_t;

endpackage

FILE: design/fsde_digit_file.sv
// fsde_digit_file: the digit store, one read and one write position per cycle,
// plus a clear of all positions from a given index up. No package dependency.
module fsde_digit_file #(
  parameter int MAX_DIGITS = 16,
  parameter int DIGIT_BITS = 4,
  localparam int CNT_W = $clog2(MAX_DIGITS + 1),
  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [IDX_W-1:0]      rd_idx,
  output logic [DIGIT_BITS-1:0] rd_data,
  input  logic                  wr_en,
  input  logic [IDX_W-1:0]      wr_idx,
  input  logic [DIGIT_BITS-1:0] wr_data,
  input  logic                  clr_en,
  input  logic [CNT_W-1:0]      clr_from
);

  logic [DIGIT_BITS-1:0] store [MAX_DIGITS];

  assign rd_data = store[rd_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_DIGITS; k++) begin
        store[k] <= '0;
      end
    end else begin
      if (wr_en) begin
        store[wr_idx] <= wr_data;
      end
      // drop positions that fall outside the new digit count
      if (clr_en) begin
        for (int k = 0; k < MAX_DIGITS; k++) begin
          if (CNT_W'(k) >= clr_from) begin
            store[k] <= '0;
          end
        end
      end
    end
  end

endmodule

FILE: design/fsde_digit_alu.sv
// fsde_digit_alu: the shared per-digit unit; computes the new digit of one position
// for the current operation and updates the running flags. Depends on fsde_pkg.
module fsde_digit_alu #(
  parameter int MAX_DIGITS = 16,
  parameter int DIGIT_BITS = 4,
  localparam int CNT_W = $clog2(MAX_DIGITS + 1)
) (
  input  fsde_pkg::op_t                 op,
  input  logic [CNT_W-1:0]              position,
  input  logic [DIGIT_BITS-1:0]         digit,
  input  logic [DIGIT_BITS-1:0]         top_digit,
  input  logic [CNT_W-1:0]              pos,
  input  logic [CNT_W-1:0]              pack_cnt,
  input  logic [fsde_pkg::CFG_W-1:0]    target,
  input  logic [fsde_pkg::FIELD_W-1:0]  load_index,
  input  logic [fsde_pkg::FIELD_W-1:0]  load_value,
  input  logic [fsde_pkg::FIELD_W-1:0]  rank,
  input  logic [CNT_W-1:0]              cnt,
  input  fsde_pkg::track_t              trk,
  output logic [DIGIT_BITS-1:0]         new_digit,
  output logic [DIGIT_BITS-1:0]         out_digit,
  output logic                          wr_en,
  output logic                          nz,
  output logic [CNT_W-1:0]              cnt_next,
  output fsde_pkg::track_t              trk_next
);

  import fsde_pkg::*;

  localparam logic [DIGIT_BITS-1:0] ONE = DIGIT_BITS'(1);

  logic [CFG_W-1:0]      ix;
  logic [DIGIT_BITS-1:0] sat_value;
  logic                  hit_now;

  assign ix = CFG_W'(position);
  assign sat_value = (load_value > FIELD_W'(top_digit)) ? top_digit
                                                        : DIGIT_BITS'(load_value);

  always_comb begin
    new_digit = digit;
    wr_en     = 1'b0;
    hit_now   = 1'b0;
    nz        = (digit != '0);
    unique case (op)
      OP_ADVANCE: begin
        // pack the nonzero digits below the step position as ones, bump it
        if (ix < CFG_W'(pos)) begin
          new_digit = (ix < CFG_W'(pack_cnt)) ? ONE : '0;
          wr_en     = 1'b1;
        end else if (ix == CFG_W'(pos)) begin
          new_digit = digit + ONE;
          wr_en     = 1'b1;
        end
      end
      OP_QUERY: begin
        hit_now = nz && !trk.hit && (CFG_W'(cnt) == CFG_W'(rank));
      end
      OP_LOAD: begin
        if (ix == CFG_W'(load_index)) begin
          new_digit = sat_value;
          wr_en     = 1'b1;
        end
      end
      OP_FIRST: begin
        new_digit = (ix < target) ? ONE : '0;
        wr_en     = 1'b1;
      end
      default: begin
      end
    endcase

    out_digit = hit_now ? '0 : new_digit;

    trk_next.seen    = trk.seen | (new_digit != '0);
    trk_next.inc     = trk.inc | ((new_digit < top_digit) && trk_next.seen);
    trk_next.zab     = trk.zab | (trk.prev_nz && (new_digit == '0));
    trk_next.prev_nz = (new_digit != '0);
    trk_next.hit     = trk.hit | hit_now;

    cnt_next = cnt + CNT_W'(nz && !trk.hit);
  end

endmodule

FILE: design/fixed_support_digit_enumerator_core.sv
// An advance after the first takes a scan of up to n positions and a rewrite pass of n
// positions; every other request takes one pass; with n = 0 a request is answered
// without a pass. The shared digit unit handles one position per cycle. One item at a
// time; busy is high meanwhile. done is a one-cycle strobe; the receiver cannot stall.
// Synchronous reset clears the digits, the started flag and loads the configuration
// defaults (16, 2, 1).
module fixed_support_digit_enumerator_core #(
  parameter int MAX_DIGITS = 16,
  parameter int DIGIT_BITS = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [fsde_pkg::REQ_W-1:0]        req_type,
  input  logic [fsde_pkg::FIELD_W-1:0]      digit_index,
  input  logic [fsde_pkg::FIELD_W-1:0]      digit_value,
  input  logic [fsde_pkg::FIELD_W-1:0]      nonzero_rank,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fsde_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fsde_pkg::CFG_W-1:0]        cfg_data,
  output logic                              done,
  output logic [fsde_pkg::VEC_W-1:0]        digit_vector,
  output logic                              has_more,
  output logic                              not_found
);

  import fsde_pkg::*;

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam logic [CFG_W-1:0] MAX_COUNT = CFG_W'(MAX_DIGITS);
  localparam logic [CFG_W-1:0] RADIX_MAX = CFG_W'(2 ** DIGIT_BITS);
  localparam logic [CFG_W-1:0] RADIX_MIN = CFG_W'(2);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_PASS} state_t;

  // Positions in use: the count register saturated to the store depth.
  function automatic logic [CNT_W-1:0] used_len(input logic [CFG_W-1:0] v);
    return (v > MAX_COUNT) ? CNT_W'(MAX_COUNT) : CNT_W'(v);
  endfunction

  // Configuration registers
  logic [CFG_W-1:0] cfg_count;
  logic [CFG_W-1:0] cfg_radix;
  logic [CFG_W-1:0] cfg_target;
  logic             cfg_wr;

  // Sequencer registers
  state_t              state;
  op_t                 op;
  logic                started;
  logic [CNT_W-1:0]    i;
  logic [CNT_W-1:0]    pos;
  logic [CNT_W-1:0]    pack_cnt;
  logic [CNT_W-1:0]    cnt;
  track_t              trk;
  logic [FIELD_W-1:0]  load_index;
  logic [FIELD_W-1:0]  load_value;
  logic [FIELD_W-1:0]  rank;

  // Combinational
  logic [CNT_W-1:0]      n;
  logic [CFG_W-1:0]      radix_sat;
  logic [DIGIT_BITS-1:0] top_digit;
  logic [IDX_W-1:0]      idx;
  logic                  last;
  op_t                   op_start;
  logic                  started_new;
  logic [DIGIT_BITS-1:0] rd_data;
  logic [DIGIT_BITS-1:0] new_digit;
  logic [DIGIT_BITS-1:0] out_digit;
  logic                  alu_we;
  logic                  wr_en;
  logic                  nz;
  logic [CNT_W-1:0]      cnt_next;
  track_t                trk_next;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = !busy;
  assign cfg_wr    = cfg_valid && cfg_ready;

  assign n         = used_len(cfg_count);
  assign radix_sat = (cfg_radix < RADIX_MIN) ? RADIX_MIN :
                     (cfg_radix > RADIX_MAX) ? RADIX_MAX : cfg_radix;
  assign top_digit = DIGIT_BITS'(radix_sat - CFG_W'(1));
  assign idx       = i[IDX_W-1:0];
  assign last      = (i == n - CNT_W'(1));
  assign wr_en     = (state == S_PASS) && alu_we;

  // Choose the per-position operation for a new item.
  always_comb begin
    op_start    = OP_KEEP;
    started_new = started;
    unique case (req_type)
      REQ_ADVANCE: begin
        op_start    = started ? OP_SCAN : OP_FIRST;
        started_new = 1'b1;
      end
      REQ_QUERY:   op_start = OP_QUERY;
      REQ_LOAD:    op_start = OP_LOAD;
      REQ_RESTART: begin
        op_start    = OP_FIRST;
        started_new = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Configuration registers; written only while idle.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_count  <= COUNT_RESET;
      cfg_radix  <= RADIX_RESET;
      cfg_target <= TARGET_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_DIGIT_COUNT: cfg_count  <= cfg_data;
        CFG_RADIX:       cfg_radix  <= cfg_data;
        CFG_TARGET:      cfg_target <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  fsde_digit_file #(
    .MAX_DIGITS (MAX_DIGITS),
    .DIGIT_BITS (DIGIT_BITS)
  ) u_file (
    .clk      (clk),
    .rst      (rst),
    .rd_idx   (idx),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_idx   (idx),
    .wr_data  (new_digit),
    .clr_en   (cfg_wr && (cfg_index == CFG_DIGIT_COUNT)),
    .clr_from (used_len(cfg_data))
  );

  fsde_digit_alu #(
    .MAX_DIGITS (MAX_DIGITS),
    .DIGIT_BITS (DIGIT_BITS)
  ) u_alu (
    .op         (op),
    .position   (i),
    .digit      (rd_data),
    .top_digit  (top_digit),
    .pos        (pos),
    .pack_cnt   (pack_cnt),
    .target     (cfg_target),
    .load_index (load_index),
    .load_value (load_value),
    .rank       (rank),
    .cnt        (cnt),
    .trk        (trk),
    .new_digit  (new_digit),
    .out_digit  (out_digit),
    .wr_en      (alu_we),
    .nz         (nz),
    .cnt_next   (cnt_next),
    .trk_next   (trk_next)
  );

  // Sequencer. An advance first scans upward for the lowest increasable position
  // (the inc flag of the running track), then rewrites the store in one pass.
  // Every pass also rebuilds the result vector and the has-more flag from the digits
  // it leaves behind; a query shows its found digit as zero in the vector only.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      op           <= OP_KEEP;
      started      <= 1'b0;
      done         <= 1'b0;
      i            <= '0;
      pos          <= '0;
      pack_cnt     <= '0;
      cnt          <= '0;
      trk          <= '0;
      digit_vector <= '0;
      has_more     <= 1'b0;
      not_found    <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          // no positions in use: answer at once
          done <= start && (n == '0);
          if (start) begin
            load_index   <= digit_index;
            load_value   <= digit_value;
            rank         <= nonzero_rank;
            i            <= '0;
            cnt          <= '0;
            trk          <= '0;
            digit_vector <= '0;
            op           <= op_start;
            started      <= started_new;
            if (n == '0) begin
              has_more  <= !started_new;
              not_found <= (req_type == REQ_QUERY);
            end else begin
              state <= (op_start == OP_SCAN) ? S_SCAN : S_PASS;
            end
          end
        end
        S_SCAN: begin
          done <= 1'b0;
          if (trk_next.inc) begin
            // step here; a zero digit takes the one below it, so pack one fewer
            pos      <= i;
            pack_cnt <= cnt - CNT_W'(!nz);
            op       <= OP_ADVANCE;
            state    <= S_PASS;
            i        <= '0;
            cnt      <= '0;
            trk      <= '0;
          end else if (last) begin
            // nothing can be increased: hold the vector
            op    <= OP_KEEP;
            state <= S_PASS;
            i     <= '0;
            cnt   <= '0;
            trk   <= '0;
          end else begin
            trk <= trk_next;
            cnt <= cnt_next;
            i   <= i + CNT_W'(1);
          end
        end
        S_PASS: begin
          done <= last;
          trk  <= trk_next;
          cnt  <= cnt_next;
          i    <= i + CNT_W'(1);
          digit_vector[SLOT_BITS*idx +: SLOT_BITS] <= SLOT_BITS'(out_digit);
          if (last) begin
            state     <= S_IDLE;
            has_more  <= !started || trk_next.inc || trk_next.zab;
            not_found <= (op == OP_QUERY) && !trk_next.hit;
          end
        end
        default: begin
          state <= S_IDLE;
          done  <= 1'b0;
        end
      endcase
    end
  end

  // A result comes only from the end of a pass or an immediate answer.
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == S_PASS) || $past(start && !busy))
    else $error("result strobe without a finished item");

  // The position counter stays inside the positions in use while working.
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (i < n))
    else $error("position counter out of range");

  // A scan for the next pattern only runs once the first pattern is loaded.
  a_scan_started: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> started)
    else $error("scan before first pattern");

  // An advance never rewrites digits above its step position.
  a_advance_bound: assert property (@(posedge clk) disable iff (rst)
    (wr_en && (op == OP_ADVANCE)) |-> (i <= pos))
    else $error("advance wrote above step position");

  // Only a neighbor query can report a missing digit.
  a_not_found_query: assert property (@(posedge clk) disable iff (rst)
    (done && not_found) |-> (op == OP_QUERY))
    else $error("not_found on a request other than a query");

endmodule

FILE: test/fixed_support_digit_enumerator_core_tb.sv
// Self-checking testbench for fixed_support_digit_enumerator_core: directed and random
// requests under random register settings, checked against an in-bench digit predictor.
// Depends on fsde_pkg and the core module only.
module fixed_support_digit_enumerator_core_tb;
  import fsde_pkg::*;

  localparam int     MAX_DIGITS   = 16;
  localparam int     DIGIT_BITS   = 4;
  localparam int     RANDOM_ITEMS = 1900;
  // Settle time at the end, longer than the worst-case answer.
  localparam int     SETTLE_CYCLES = 40;
  // Slowest legal run is about 2000 items, each with a full busy spell and the longest idle gap.
  localparam int     CYCLE_LIMIT  = 1000000;
  localparam int     MAX_REPORTS  = 10;

  // One result as seen on the output ports.
  typedef struct packed {
    logic [VEC_W-1:0] digit_vector;
    logic             has_more;
    logic             not_found;
  } outcome_t;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [REQ_W-1:0]     req_type;
  logic [FIELD_W-1:0]   digit_index;
  logic [FIELD_W-1:0]   digit_value;
  logic [FIELD_W-1:0]   nonzero_rank;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 done;
  logic [VEC_W-1:0]     digit_vector;
  logic                 has_more;
  logic                 not_found;

  fixed_support_digit_enumerator_core #(
    .MAX_DIGITS(MAX_DIGITS),
    .DIGIT_BITS(DIGIT_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req_type(req_type),
    .digit_index(digit_index),
    .digit_value(digit_value),
    .nonzero_rank(nonzero_rank),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .done(done),
    .digit_vector(digit_vector),
    .has_more(has_more),
    .not_found(not_found)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: digits, started flag and the three registers.
  // ---------------------------------------------------------------------------
  logic [DIGIT_BITS-1:0] digits [MAX_DIGITS];
  logic                  started;
  logic [CFG_W-1:0]      count_reg;
  logic [CFG_W-1:0]      radix_reg;
  logic [CFG_W-1:0]      target_reg;

  // Results predicted at acceptance, oldest first.
  outcome_t pending_outcomes [$];

  int  cycle_count;
  int  mismatches;
  int  items_sent;
  int  results_checked;
  int  exhausted_results;
  int  settings_used;
  bit  no_idle;

  // Positions in use: saturate the count at the store depth.
  function automatic int positions_used();
    return (count_reg > MAX_DIGITS) ? MAX_DIGITS : int'(count_reg);
  endfunction

  // Largest digit value: radix clamped into 2..2^DIGIT_BITS, minus one.
  function automatic logic [DIGIT_BITS-1:0] top_value();
    int r;
    r = int'(radix_reg);
    if (r < 2) r = 2;
    if (r > (1 << DIGIT_BITS)) r = 1 << DIGIT_BITS;
    return DIGIT_BITS'(r - 1);
  endfunction

  function automatic void load_first_pattern();
    int n;
    n = positions_used();
    for (int i = 0; i < MAX_DIGITS; i++)
      digits[i] = (i < n && i < int'(target_reg)) ? 4'd1 : 4'd0;
  endfunction

  // Lowest position below the top value at or above the first nonzero digit.
  function automatic int lowest_increasable();
    int n;
    logic [DIGIT_BITS-1:0] top;
    logic seen;
    n = positions_used();
    top = top_value();
    seen = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (digits[i] != 0) seen = 1'b1;
      if (seen && digits[i] < top) return i;
    end
    return n;
  endfunction

  function automatic logic zero_above_nonzero();
    int n;
    n = positions_used();
    for (int i = 0; i + 1 < n; i++)
      if (digits[i] != 0 && digits[i+1] == 0) return 1'b1;
    return 1'b0;
  endfunction

  // Repack the nonzero digits below pos as ones at the bottom.
  function automatic void pack_low(input int pos);
    int cnt;
    cnt = 0;
    for (int i = 0; i < pos; i++)
      if (digits[i] != 0) cnt++;
    for (int i = 0; i < pos; i++)
      digits[i] = (i < cnt) ? 4'd1 : 4'd0;
  endfunction

  function automatic logic more_ahead();
    if (!started) return 1'b1;
    return (lowest_increasable() < positions_used()) || zero_above_nonzero();
  endfunction

  function automatic logic [VEC_W-1:0] packed_digits();
    logic [VEC_W-1:0] vec;
    int n;
    vec = '0;
    n = positions_used();
    for (int i = 0; i < n; i++)
      vec[SLOT_BITS*i +: SLOT_BITS] = digits[i];
    return vec;
  endfunction

  function automatic void advance_digits();
    int pos;
    if (!started) begin
      started = 1'b1;
      load_first_pattern();
      return;
    end
    pos = lowest_increasable();
    if (pos >= positions_used()) return;
    if (pos > 0 && digits[pos] == 0) digits[pos-1] = '0;
    digits[pos] = digits[pos] + 1'b1;
    pack_low(pos);
  endfunction

  // Apply one request to the predictor state and return its result.
  function automatic outcome_t predict_item(input logic [REQ_W-1:0] req,
                                            input logic [FIELD_W-1:0] idx,
                                            input logic [FIELD_W-1:0] val,
                                            input logic [FIELD_W-1:0] rank);
    outcome_t res;
    int n;
    int cnt;
    logic hit;
    logic [DIGIT_BITS-1:0] top;
    res = '0;
    n = positions_used();
    top = top_value();
    case (req)
      REQ_ADVANCE: begin
        advance_digits();
        res.digit_vector = packed_digits();
      end
      REQ_QUERY: begin
        // Clear the rank-th nonzero digit in a copy; the state stays as it is.
        res.digit_vector = packed_digits();
        hit = 1'b0;
        cnt = 0;
        for (int i = 0; i < n; i++) begin
          if (!hit && digits[i] != 0) begin
            if (cnt == int'(rank)) begin
              res.digit_vector[SLOT_BITS*i +: SLOT_BITS] = '0;
              hit = 1'b1;
            end
            cnt++;
          end
        end
        res.not_found = !hit;
      end
      REQ_LOAD: begin
        if (int'(idx) < n) digits[idx] = (val > top) ? top : val;
        res.digit_vector = packed_digits();
      end
      default: begin
        load_first_pattern();
        started = 1'b1;
        res.digit_vector = packed_digits();
      end
    endcase
    res.has_more = more_ahead();
    return res;
  endfunction

  function automatic void apply_register(input logic [CFG_IDX_W-1:0] index,
                                         input logic [CFG_W-1:0] data);
    case (index)
      CFG_DIGIT_COUNT: begin
        count_reg = data;
        // Positions that fall out of use are cleared.
        for (int i = positions_used(); i < MAX_DIGITS; i++) digits[i] = '0;
      end
      CFG_RADIX:  radix_reg = data;
      CFG_TARGET: target_reg = data;
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking: every done strobe is matched against the oldest prediction.
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(input string what, input logic [VEC_W-1:0] want,
                               input logic [VEC_W-1:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("cycle %0d: %s: expected %h, got %h", cycle_count, what, want, got);
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (!rst && done) begin
      if (pending_outcomes.size() == 0) begin
        flag_mismatch("result with nothing pending", '0, digit_vector);
      end else begin
        want = pending_outcomes.pop_front();
        results_checked++;
        if (!want.has_more) exhausted_results++;
        if (digit_vector !== want.digit_vector)
          flag_mismatch("digit_vector", want.digit_vector, digit_vector);
        if (has_more !== want.has_more)
          flag_mismatch("has_more", VEC_W'(want.has_more), VEC_W'(has_more));
        if (not_found !== want.not_found)
          flag_mismatch("not_found", VEC_W'(want.not_found), VEC_W'(not_found));
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("run stopped at the cycle limit with %0d results pending",
               pending_outcomes.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Present one item and hold it until the block takes it, then predict it.
  task automatic send_item(input logic [REQ_W-1:0] req, input logic [FIELD_W-1:0] idx,
                           input logic [FIELD_W-1:0] val, input logic [FIELD_W-1:0] rank);
    @(negedge clk);
    req_type     = req;
    digit_index  = idx;
    digit_value  = val;
    nonzero_rank = rank;
    start        = 1'b1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    pending_outcomes.push_back(predict_item(req, idx, val, rank));
    items_sent++;
  endtask

  // Drop start for a random gap: mostly none or short, now and then long.
  task automatic idle_gap();
    int pick;
    int len;
    if (no_idle) return;
    pick = $urandom_range(0, 15);
    if (pick < 8) len = 0;
    else if (pick < 14) len = $urandom_range(1, 3);
    else len = $urandom_range(10, 60);
    if (len == 0) return;
    @(negedge clk);
    start = 1'b0;
    repeat (len - 1) @(negedge clk);
  endtask

  // Hold off the sender until every predicted result has come back.
  task automatic drain_results();
    @(negedge clk);
    start = 1'b0;
    while (pending_outcomes.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Write one register while the block is idle.
  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_W-1:0] data);
    drain_results();
    cfg_index = index;
    cfg_data  = data;
    cfg_valid = 1'b1;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    apply_register(index, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic configure(input logic [CFG_W-1:0] count, input logic [CFG_W-1:0] radix,
                           input logic [CFG_W-1:0] target);
    write_register(CFG_DIGIT_COUNT, count);
    write_register(CFG_RADIX, radix);
    write_register(CFG_TARGET, target);
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Defaults after reset: not started, so a load is overwritten by the first pattern.
  task automatic test_power_on();
    send_item(REQ_QUERY, 4'd0, 4'd0, 4'd0);
    send_item(REQ_LOAD, 4'd3, 4'd15, 4'd0);
    send_item(REQ_ADVANCE, 4'd0, 4'd0, 4'd0);
    send_item(REQ_ADVANCE, 4'd15, 4'd15, 4'd15);
    send_item(REQ_QUERY, 4'd0, 4'd0, 4'd0);
    send_item(REQ_QUERY, 4'd0, 4'd0, 4'd15);
  endtask

  // Widest setting: all sixteen positions full at the largest radix.
  task automatic test_wide_radix();
    configure(5'd16, 5'd16, 5'd16);
    send_item(REQ_RESTART, 4'd0, 4'd0, 4'd0);
    send_item(REQ_ADVANCE, 4'd0, 4'd0, 4'd0);
    send_item(REQ_LOAD, 4'd15, 4'd15, 4'd0);
    send_item(REQ_LOAD, 4'd0, 4'd0, 4'd0);
    send_item(REQ_QUERY, 4'd0, 4'd0, 4'd15);
    send_item(REQ_ADVANCE, 4'd0, 4'd0, 4'd0);
  endtask

  // One position: an empty pattern and a saturated one both leave nothing to advance.
  task automatic test_no_advance();
    configure(5'd1, 5'd2, 5'd0);
    send_item(REQ_RESTART, 4'd0, 4'd0, 4'd0);
    send_item(REQ_ADVANCE, 4'd0, 4'd0, 4'd0);
    send_item(REQ_QUERY, 4'd0, 4'd0, 4'd0);
    configure(5'd1, 5'd2, 5'd16);
    send_item(REQ_RESTART, 4'd0, 4'd0, 4'd0);
    send_item(REQ_ADVANCE, 4'd0, 4'd0, 4'd0);
  endtask

  // Register values outside their ranges, a shrinking count, a load past the end.
  task automatic test_out_of_range();
    configure(5'd0, 5'd0, 5'd31);
    send_item(REQ_RESTART, 4'd0, 4'd0, 4'd0);
    send_item(REQ_ADVANCE, 4'd0, 4'd0, 4'd0);
    send_item(REQ_LOAD, 4'd0, 4'd9, 4'd0);
    configure(5'd31, 5'd31, 5'd31);
    send_item(REQ_RESTART, 4'd0, 4'd0, 4'd0);
    send_item(REQ_LOAD, 4'd15, 4'd15, 4'd0);
    configure(5'd4, 5'd17, 5'd2);
    send_item(REQ_ADVANCE, 4'd0, 4'd0, 4'd0);
    send_item(REQ_LOAD, 4'd10, 4'd5, 4'd0);
  endtask

  // Random phases: a register setting, a restart, then mostly advances.
  task automatic test_random_walks();
    int pick;
    int walk_len;
    int cnt;
    int random_items;
    logic [REQ_W-1:0]   req;
    logic [FIELD_W-1:0] idx;
    logic [FIELD_W-1:0] rank;
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        // extremes of the legal ranges
        cnt = $urandom_range(0, 1) ? 16 : 1;
        configure(CFG_W'(cnt), $urandom_range(0, 1) ? 5'd16 : 5'd2,
                  $urandom_range(0, 1) ? 5'd16 : 5'd0);
      end else if (pick == 1) begin
        // any 5-bit value, out-of-range ones included
        configure(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
      end else begin
        // small enumerations that run to their end within one phase
        cnt = $urandom_range(1, 6);
        configure(CFG_W'(cnt), CFG_W'($urandom_range(2, 4)),
                  CFG_W'($urandom_range(0, cnt)));
      end
      cnt = positions_used();
      no_idle = ($urandom_range(0, 3) == 0);
      send_item(REQ_RESTART, FIELD_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom));
      random_items++;
      walk_len = $urandom_range(20, 80);
      repeat (walk_len) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) req = REQ_ADVANCE;
        else if (pick < 82) req = REQ_QUERY;
        else if (pick < 92) req = REQ_LOAD;
        else req = REQ_RESTART;
        // aim most loads and queries at digits that exist
        if ($urandom_range(0, 3) != 0 && cnt > 0) idx = FIELD_W'($urandom_range(0, cnt - 1));
        else idx = FIELD_W'($urandom);
        if ($urandom_range(0, 1) != 0) rank = FIELD_W'($urandom_range(0, 3));
        else rank = FIELD_W'($urandom);
        send_item(req, idx, FIELD_W'($urandom), rank);
        random_items++;
        idle_gap();
        // now and then let the block run dry in mid-phase
        if ($urandom_range(0, 49) == 0) drain_results();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    req_type     = REQ_ADVANCE;
    digit_index  = '0;
    digit_value  = '0;
    nonzero_rank = '0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_DIGIT_COUNT;
    cfg_data     = '0;
    cycle_count  = 0;
    mismatches   = 0;
    items_sent   = 0;
    results_checked   = 0;
    exhausted_results = 0;
    settings_used     = 1;
    no_idle      = 1'b0;
    // Predictor takes its reset state.
    for (int i = 0; i < MAX_DIGITS; i++) digits[i] = '0;
    started    = 1'b0;
    count_reg  = COUNT_RESET;
    radix_reg  = RADIX_RESET;
    target_reg = TARGET_RESET;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_power_on();
    test_wide_radix();
    test_no_advance();
    test_out_of_range();
    test_random_walks();

    // Drop start, wait out the last results, then let the block settle.
    @(negedge clk);
    start = 1'b0;
    while (pending_outcomes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Sent %0d items under %0d register settings; checked %0d results,",
             items_sent, settings_used, results_checked);
    $display("%0d of them with the enumeration exhausted, in %0d cycles.",
             exhausted_results, cycle_count);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: fixed_support_digit_enumerator_core.f
design/fsde_pkg.sv
design/fsde_digit_file.sv
design/fsde_digit_alu.sv
design/fixed_support_digit_enumerator_core.sv
test/fixed_support_digit_enumerator_core_tb.sv
